### rtl/pdg_pkg.sv
// ----------------------------------------------------------------------------
// pdg_pkg
// Shared widths, codes, types and helpers of the particle density grid deposit.
// ----------------------------------------------------------------------------
package pdg_pkg;

  localparam int MAX_COMPONENTS = 2;
  localparam int MAX_CHANNELS   = 4;
  localparam int MAX_AXIS       = 32;
  localparam int FRAC_BITS      = 16;

  localparam int COMP_W = 1;
  localparam int CH_W   = 2;
  localparam int AXIS_W = 5;
  localparam int PTS_W  = 6;
  localparam int CELL_W = 40;
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int ADDR_W = COMP_W + CH_W + 3 * AXIS_W;
  localparam int LIST_MAX = 4;

  localparam logic [WGT_W-1:0]  W_ONE    = WGT_W'(1) << FRAC_BITS;
  localparam logic [WGT_W-1:0]  W_HALF   = WGT_W'(1) << (FRAC_BITS - 1);
  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  // input commands
  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // result status
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_SKIPPED = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_PTS_X = 3'd1;
  localparam logic [2:0] REG_PTS_Y = 3'd2;
  localparam logic [2:0] REG_PTS_Z = 3'd3;
  localparam logic [2:0] REG_TLEN  = 3'd4;
  localparam logic [2:0] REG_TLIST = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_READ,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [AXIS_W-1:0] left;
    logic [AXIS_W-1:0] right;
    logic [WGT_W-1:0]  wl;
    logic [WGT_W-1:0]  wr;
  } axis_pair_t;

  function automatic logic [PTS_W-1:0] eff_points(input logic [PTS_W-1:0] v);
    if (v == '0) begin
      return PTS_W'(1);
    end else if (v > PTS_W'(MAX_AXIS)) begin
      return PTS_W'(MAX_AXIS);
    end
    return v;
  endfunction

endpackage

### rtl/pdg_axis.sv
// ----------------------------------------------------------------------------
// pdg_axis
// Neighbor pair and weights along one axis for a wrapped fractional position.
// ----------------------------------------------------------------------------
module pdg_axis (
  input  logic                      equitable,
  input  logic [pdg_pkg::FRAC_BITS-1:0] frac,
  input  logic [pdg_pkg::PTS_W-1:0] points,
  output pdg_pkg::axis_pair_t       pair
);
  import pdg_pkg::*;

  logic [PTS_W+FRAC_BITS-1:0] g;
  logic [AXIS_W-1:0]          fl;
  logic [AXIS_W-1:0]          last;
  logic [WGT_W-1:0]           part;

  assign g    = PTS_W'(points) * (PTS_W + FRAC_BITS)'(frac);
  assign fl   = g[FRAC_BITS +: AXIS_W];
  assign last = AXIS_W'(points - PTS_W'(1));
  assign part = WGT_W'(g[FRAC_BITS-1:0]);

  always_comb begin
    if (!equitable) begin
      // nearest bin with full weight on the left member only
      pair.left  = fl;
      pair.right = fl;
      pair.wl    = W_ONE;
      pair.wr    = '0;
    end else if (part > W_HALF) begin
      pair.left  = fl;
      pair.right = (fl == last) ? '0 : fl + AXIS_W'(1);
      pair.wl    = W_ONE + W_HALF - part;
      pair.wr    = part - W_HALF;
    end else begin
      pair.left  = (fl == '0) ? last : fl - AXIS_W'(1);
      pair.right = fl;
      pair.wl    = W_HALF - part;
      pair.wr    = W_HALF + part;
    end
  end

endmodule

### rtl/pdg_mem.sv
// ----------------------------------------------------------------------------
// pdg_mem
// Density store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdg_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pdg_pkg::ADDR_W-1:0] wr_addr,
  input  logic [pdg_pkg::CELL_W-1:0] wr_data,
  input  logic [pdg_pkg::ADDR_W-1:0] rd_addr,
  output logic [pdg_pkg::CELL_W-1:0] rd_data
);
  import pdg_pkg::*;

  logic [CELL_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/particle_density_grid_deposit.sv
// ----------------------------------------------------------------------------
// particle_density_grid_deposit
// 3-D density histogram with nearest-bin or cloud-in-cell deposit.
// ----------------------------------------------------------------------------
// Steps, accept edge to result valid: sample, skip and out-of-range items go
//   straight to the result load; a cell read reads the store first; a deposit
//   runs setup, the read-modify-writes (one cell in standard mode, eight one a
//   cycle in equitable mode), a drain of the update pipeline, then the load.
// Throughput: one item at a time; the next transfer can be taken in the cycle
//   after the result loads.
// Reset: synchronous, active low; after reset the store is cleared one cell a
//   cycle until all 262144 cells are zero; in_stall stays high meanwhile.
module particle_density_grid_deposit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [0:0]                 in_component,
  input  logic [7:0]                 in_atom_type,
  input  logic                       in_is_fractional,
  input  logic signed [31:0]         in_pos_x,
  input  logic signed [31:0]         in_pos_y,
  input  logic signed [31:0]         in_pos_z,
  input  logic [1:0]                 in_read_channel,
  input  logic [4:0]                 in_read_x,
  input  logic [4:0]                 in_read_y,
  input  logic [4:0]                 in_read_z,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdg_pkg::CELL_W-1:0] out_cell_value,
  output logic [31:0]                out_sample_count,
  output logic [1:0]                 out_status,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pdg_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic              mode_r;
  logic [PTS_W-1:0]  pts_x_r, pts_y_r, pts_z_r;
  logic [2:0]        tlen_r;
  logic [31:0]       tlist_r;
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      pts_x_r <= PTS_W'(MAX_AXIS);
      pts_y_r <= PTS_W'(MAX_AXIS);
      pts_z_r <= PTS_W'(MAX_AXIS);
      tlen_r  <= '0;
      tlist_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:  mode_r  <= pwdata[0];
        REG_PTS_X: pts_x_r <= pwdata[PTS_W-1:0];
        REG_PTS_Y: pts_y_r <= pwdata[PTS_W-1:0];
        REG_PTS_Z: pts_z_r <= pwdata[PTS_W-1:0];
        REG_TLEN:  tlen_r  <= pwdata[2:0];
        REG_TLIST: tlist_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = 32'(mode_r);
      REG_PTS_X: prdata = 32'(pts_x_r);
      REG_PTS_Y: prdata = 32'(pts_y_r);
      REG_PTS_Z: prdata = 32'(pts_z_r);
      REG_TLEN:  prdata = 32'(tlen_r);
      REG_TLIST: prdata = tlist_r;
      default:   prdata = '0;
    endcase
  end

  // Effective grid sizes: zero acts as one, anything above the store as its max.
  logic [PTS_W-1:0] eff_x, eff_y, eff_z;
  assign eff_x = eff_points(pts_x_r);
  assign eff_y = eff_points(pts_y_r);
  assign eff_z = eff_points(pts_z_r);

  // --------------------------------------------------------------------------
  // Accept-time decode: channel lookup, skip and range checks
  // --------------------------------------------------------------------------
  logic [2:0]      list_len;
  logic [2:0]      num_ch;
  logic            found;
  logic [CH_W-1:0] dep_ch;
  logic            dep_skip;
  logic            rd_bad;

  always_comb begin
    list_len = (tlen_r > 3'(LIST_MAX)) ? 3'(LIST_MAX) : tlen_r;
    if (list_len > 3'(MAX_CHANNELS)) begin
      list_len = 3'(MAX_CHANNELS);
    end
    num_ch = (list_len == '0) ? 3'd1 : list_len;
    found  = 1'b0;
    dep_ch = '0;
    // first matching byte wins
    for (int k = 0; k < LIST_MAX; k++) begin
      if (!found && (3'(k) < list_len) && (tlist_r[8*k +: 8] == in_atom_type)) begin
        found  = 1'b1;
        dep_ch = CH_W'(k);
      end
    end
    dep_skip = in_is_fractional ||
               (32'(in_component) >= 32'(MAX_COMPONENTS)) ||
               ((list_len != '0) && !found);
    rd_bad   = (32'(in_component) >= 32'(MAX_COMPONENTS)) ||
               (3'(in_read_channel) >= num_ch) ||
               (PTS_W'(in_read_x) >= eff_x) ||
               (PTS_W'(in_read_y) >= eff_y) ||
               (PTS_W'(in_read_z) >= eff_z);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [2:0]        k_r;
  logic              in_xfer;
  logic              out_xfer;
  logic              clr_last;
  logic              k_last;
  logic              s1_valid_r, s2_valid_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign clr_last = (clr_addr_r == '1);
  // standard mode touches one cell, equitable mode all eight neighbors
  assign k_last   = mode_r ? (k_r == 3'd7) : (k_r == 3'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == CMD_DEPOSIT && !dep_skip) begin
            state_nxt = ST_SETUP;
          end else if (in_cmd == CMD_READ && !rd_bad) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SETUP:  state_nxt = ST_ISSUE;
      ST_ISSUE:  if (k_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!s1_valid_r && !s2_valid_r) state_nxt = ST_DONE;
      ST_READ:   state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  logic clearing, issuing, loading_out;
  always_comb begin
    clearing    = (state_r == ST_CLEAR);
    issuing     = (state_r == ST_ISSUE);
    in_stall    = (state_r != ST_IDLE);
    loading_out = (state_r == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      k_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      // advance the neighbor counter while issuing, rewind otherwise
      k_r <= issuing ? k_r + 3'd1 : 3'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Item registers
  // --------------------------------------------------------------------------
  logic [COMP_W-1:0]    comp_r;
  logic [CH_W-1:0]      ch_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;
  logic [ADDR_W-1:0]    rd_cell_r;
  logic [31:0]          samples_r;
  logic [CELL_W-1:0]    res_value_r;
  logic [1:0]           res_status_r;
  logic [CELL_W-1:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= '0;
    end else if (in_xfer && in_cmd == CMD_SAMPLE) begin
      samples_r <= samples_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      comp_r <= in_component;
      ch_r   <= dep_ch;
      // keep only the fraction bits: wraps the position into [0,1)
      fx_r   <= in_pos_x[FRAC_BITS-1:0];
      fy_r   <= in_pos_y[FRAC_BITS-1:0];
      fz_r   <= in_pos_z[FRAC_BITS-1:0];
      rd_cell_r <= {in_component, in_read_channel, in_read_x, in_read_y, in_read_z};
      res_value_r <= '0;
      if (in_cmd == CMD_DEPOSIT && dep_skip) begin
        res_status_r <= STS_SKIPPED;
      end else if (in_cmd == CMD_READ && rd_bad) begin
        res_status_r <= STS_RANGE;
      end else begin
        res_status_r <= STS_DONE;
      end
    end else if (state_r == ST_RDWAIT) begin
      res_value_r <= mem_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis neighbor pairs, registered in the setup cycle
  // --------------------------------------------------------------------------
  axis_pair_t pair_x, pair_y, pair_z;
  axis_pair_t pair_x_r, pair_y_r, pair_z_r;

  pdg_axis u_axis_x (.equitable(mode_r), .frac(fx_r), .points(eff_x), .pair(pair_x));
  pdg_axis u_axis_y (.equitable(mode_r), .frac(fy_r), .points(eff_y), .pair(pair_y));
  pdg_axis u_axis_z (.equitable(mode_r), .frac(fz_r), .points(eff_z), .pair(pair_z));

  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      pair_x_r <= pair_x;
      pair_y_r <= pair_y;
      pair_z_r <= pair_z;
    end
  end

  // --------------------------------------------------------------------------
  // Update pipeline: issue (read + first product), weight (second product),
  // write (forward, saturating add)
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]    iss_addr;
  logic [WGT_W-1:0]     wa, wb, wc;
  logic [2*WGT_W-1:0]   prod1, prod2;
  logic [ADDR_W-1:0]    s1_addr_r, s2_addr_r;
  logic [WGT_W-1:0]     s1_w1_r, s1_wc_r, s2_w_r;
  logic [CELL_W-1:0]    s2_rdata_r;

  always_comb begin
    iss_addr = {comp_r, ch_r,
                k_r[2] ? pair_x_r.right : pair_x_r.left,
                k_r[1] ? pair_y_r.right : pair_y_r.left,
                k_r[0] ? pair_z_r.right : pair_z_r.left};
    wa    = k_r[2] ? pair_x_r.wr : pair_x_r.wl;
    wb    = k_r[1] ? pair_y_r.wr : pair_y_r.wl;
    wc    = k_r[0] ? pair_z_r.wr : pair_z_r.wl;
    prod1 = (2*WGT_W)'(wa) * (2*WGT_W)'(wb);
    prod2 = (2*WGT_W)'(s1_w1_r) * (2*WGT_W)'(s1_wc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issuing;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= iss_addr;
    s1_w1_r    <= prod1[FRAC_BITS +: WGT_W];
    s1_wc_r    <= wc;
    s2_addr_r  <= s1_addr_r;
    s2_w_r     <= prod2[FRAC_BITS +: WGT_W];
    s2_rdata_r <= mem_rdata;
  end

  // The read for a cell went out at issue, ahead of the weight stage, so the two
  // most recent writes are not yet in the read data: forward them, newest first.
  logic              h0_valid_r, h1_valid_r;
  logic [ADDR_W-1:0] h0_addr_r, h1_addr_r;
  logic [CELL_W-1:0] h0_data_r, h1_data_r;
  logic [CELL_W-1:0] base;
  logic [CELL_W:0]   sum;
  logic [CELL_W-1:0] upd_data;

  always_comb begin
    if (h0_valid_r && h0_addr_r == s2_addr_r) begin
      base = h0_data_r;
    end else if (h1_valid_r && h1_addr_r == s2_addr_r) begin
      base = h1_data_r;
    end else begin
      base = s2_rdata_r;
    end
    sum      = (CELL_W+1)'(base) + (CELL_W+1)'(s2_w_r);
    upd_data = sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_valid_r <= 1'b0;
      h1_valid_r <= 1'b0;
    end else if (s2_valid_r) begin
      h0_valid_r <= 1'b1;
      h1_valid_r <= h0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      h0_addr_r <= s2_addr_r;
      h0_data_r <= upd_data;
      h1_addr_r <= h0_addr_r;
      h1_data_r <= h0_data_r;
    end
  end

  // --------------------------------------------------------------------------
  // Store
  // --------------------------------------------------------------------------
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    mem_we    = clearing || s2_valid_r;
    mem_waddr = clearing ? clr_addr_r : s2_addr_r;
    mem_wdata = clearing ? '0 : upd_data;
    mem_raddr = issuing ? iss_addr : rd_cell_r;
  end

  pdg_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Output register: holds a finished result until the sink takes it
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic [CELL_W-1:0] out_value_r;
  logic [31:0]       out_count_r;
  logic [1:0]        out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (loading_out) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (loading_out) begin
      out_value_r  <= res_value_r;
      out_count_r  <= samples_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_value   = out_value_r;
  assign out_sample_count = out_count_r;
  assign out_status       = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_r)
    else $error("result presented during store clear");

  a_write_follows_weight: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(s1_valid_r))
    else $error("store write without a weight stage");

  a_pipe_empty_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_valid_r && !s2_valid_r))
    else $error("update pipeline busy while idle");

  a_issue_from_deposit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(state_r == ST_ISSUE))
    else $error("weight stage loaded outside issue");

endmodule
